/* src/irm_pkg.sv */
package irm_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ACT_ASSIGN = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic signed [31:0] range_begin;
    logic signed [31:0] range_end;
    logic signed [31:0] new_value;
    logic signed [31:0] query_key;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_word_t;

endpackage

/* src/irm_front.sv */
// front: accepts words, flags empty ranges, holds a two-entry queue
module irm_front
  import irm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word_i,
  output logic     cmd_valid_o,
  input  logic     cmd_take_i,
  output in_word_t cmd_word_o,
  output logic     cmd_empty_range_o
);

  in_word_t   buf_q [2];
  logic       empty_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full = (cnt_q == 2'd2);
  assign wr_en = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd_en = cmd_valid_o && cmd_take_i;
  assign cmd_word_o = buf_q[rd_q];
  assign cmd_empty_range_o = empty_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_q]   <= in_word_i;
      empty_q[wr_q] <= !(in_word_i.range_begin < in_word_i.range_end);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= !wr_q;
      if (rd_en) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

/* src/irm_back.sv */
// back: one entry per cycle sweep over the table, then, for an assign, rebuild in place
module irm_back
  import irm_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] default_value_i,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  input  in_word_t           cmd_word_i,
  input  logic               cmd_empty_range_i,
  output logic               res_valid_o,
  output out_word_t          res_word_o,
  input  logic               res_take_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DECIDE= 5'b00100,
    S_MOVE  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q;
  logic signed [31:0] keys_q [TableDepth];
  logic signed [31:0] vals_q [TableDepth];
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  in_word_t cmd_q;
  // scan results
  logic [CntW-1:0] n_lo_q;   // entries with key < begin
  logic [CntW-1:0] n_le_q;   // entries with key <= end
  logic signed [31:0] before_q, after_q, hit_q;
  logic ins_b_q, ins_e_q;
  logic [CntW+1:0] new_cnt_q;
  logic [CntW-1:0] src_q, dst_q;
  logic signed [31:0] res_val_q;
  status_e res_st_q;
  logic [CntW-1:0] tail_q;   // entries kept above end
  logic up_q;

  logic signed [31:0] cur_k, cur_v;
  logic [IdxW-1:0] rd_idx;
  assign rd_idx = idx_q[IdxW-1:0];
  assign cur_k = keys_q[rd_idx];
  assign cur_v = vals_q[rd_idx];

  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o = (state_q == S_OUT);
  assign res_word_o.read_value = res_val_q;
  assign res_word_o.status = res_st_q;

  logic [CntW+1:0] need;
  logic [CntW-1:0] tail;
  assign tail = count_q - n_le_q;
  assign need = {2'b0, n_lo_q} + {{(CntW+1){1'b0}}, ins_b_q}
              + {{(CntW+1){1'b0}}, ins_e_q} + {2'b0, tail};

  logic [CntW-1:0] lo_ins;
  assign lo_ins = n_lo_q + {{(CntW-1){1'b0}}, ins_b_q};

  // sequencer and table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_word_i;
            idx_q    <= '0;
            n_lo_q   <= '0;
            n_le_q   <= '0;
            before_q <= default_value_i;
            after_q  <= default_value_i;
            hit_q    <= default_value_i;
            res_val_q <= '0;
            if (cmd_word_i.action == ACT_ASSIGN && cmd_empty_range_i) begin
              res_st_q <= ST_EMPTY;
              state_q  <= S_OUT;
            end else begin
              res_st_q <= ST_DONE;
              state_q  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx_q == count_q) begin
            state_q <= S_DECIDE;
          end else begin
            if (cur_k <= cmd_q.query_key) hit_q <= cur_v;
            if (cur_k < cmd_q.range_begin) begin
              before_q <= cur_v;
              n_lo_q   <= idx_q + 1'b1;
            end
            if (cur_k <= cmd_q.range_end) begin
              after_q <= cur_v;
              n_le_q  <= idx_q + 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DECIDE: begin
          if (cmd_q.action == ACT_LOOKUP) begin
            res_val_q <= hit_q;
            state_q   <= S_OUT;
          end else begin
            ins_b_q <= (cmd_q.new_value != before_q);
            ins_e_q <= (after_q != cmd_q.new_value);
            // capacity check follows in the next cycle, in the MOVE setup below
            state_q <= S_MOVE;
            idx_q   <= '0;
            up_q    <= 1'b0;
          end
        end
        S_MOVE: begin
          // first cycle: plan the move
          if (!up_q) begin
            new_cnt_q <= need;
            tail_q    <= tail;
            if (need > (CntW+2)'(TableDepth)) begin
              res_st_q <= ST_FULL;
              state_q  <= S_OUT;
            end else begin
              up_q <= 1'b1;
              idx_q <= '0;
              // shift direction: dst start vs src start
              src_q <= n_le_q;
              dst_q <= lo_ins + {{(CntW-1){1'b0}}, ins_e_q};
            end
          end else begin
            // move tail one entry per cycle, order safe for direction
            if (idx_q != tail_q) begin
              if (dst_q <= src_q) begin
                keys_q[IdxW'(dst_q + idx_q)] <= keys_q[IdxW'(src_q + idx_q)];
                vals_q[IdxW'(dst_q + idx_q)] <= vals_q[IdxW'(src_q + idx_q)];
              end else begin
                keys_q[IdxW'(dst_q + tail_q - 1'b1 - idx_q)] <=
                  keys_q[IdxW'(src_q + tail_q - 1'b1 - idx_q)];
                vals_q[IdxW'(dst_q + tail_q - 1'b1 - idx_q)] <=
                  vals_q[IdxW'(src_q + tail_q - 1'b1 - idx_q)];
              end
              idx_q <= idx_q + 1'b1;
            end else begin
              if (ins_b_q) begin
                keys_q[IdxW'(n_lo_q)] <= cmd_q.range_begin;
                vals_q[IdxW'(n_lo_q)] <= cmd_q.new_value;
              end
              if (ins_e_q) begin
                keys_q[IdxW'(lo_ins)] <= cmd_q.range_end;
                vals_q[IdxW'(lo_ins)] <= after_q;
              end
              count_q <= new_cnt_q[CntW-1:0];
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (res_take_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/interval_range_map.sv */
// flow, back end idle: a lookup scans the breakpoints held, decides and shows its result word;
//   an empty-range assign goes straight to its result word; an assign scans, decides, checks
//   capacity (a rejected assign ends there), moves the tail (breakpoints above the range end), writes
//   the new breakpoints; throughput: one word at a time in the back end, the next word taken the cycle
//   after a pop; a two-word queue buffers the input meanwhile
// reset: asynchronous active low; clears the breakpoint count, default value and queues
module interval_range_map
  import irm_pkg::*;
#(
  parameter int unsigned TableDepth = DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_word_t           in_word_i,
  output logic               empty,
  input  logic               pop,
  output out_word_t          out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [31:0] cfg_data_i
);

  logic signed [31:0] default_q;
  logic cmd_valid, cmd_take, cmd_empty, res_valid;
  in_word_t cmd_word;

  assign cfg_ready_o = 1'b1;

  // default value register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= '0;
    end else if (cfg_valid_i) begin
      default_q <= cfg_data_i;
    end
  end

  irm_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_word_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take),
    .cmd_word_o(cmd_word), .cmd_empty_range_o(cmd_empty)
  );

  irm_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .default_value_i(default_q),
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_word_i(cmd_word), .cmd_empty_range_i(cmd_empty),
    .res_valid_o(res_valid), .res_word_o(out_word_o), .res_take_i(pop)
  );

  assign empty = !res_valid;

  // a rejected assign returns a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.status == ST_FULL) |-> out_word_o.read_value == 0)
    else $error("full status with nonzero value");

  // a waiting result holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("result changed while waiting");

endmodule
